### rtl/u2c_pkg.sv
// Shared types, constants and the code point table for the UTF-8 to CP1251 transcoder.
// No dependencies; every other file of the block imports this package.
package u2c_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 11;
  localparam int unsigned LeadW  = 5;
  localparam int unsigned TabLen = 61;

  // Fixed ranges of the code point mapping.
  localparam logic [CodeW-1:0] CyrLo    = 11'h410;
  localparam logic [CodeW-1:0] CyrHi    = 11'h44F;
  localparam logic [CodeW-1:0] CyrOff   = 11'h350;
  localparam logic [CodeW-1:0] Lat1Lo   = 11'h080;
  localparam logic [CodeW-1:0] Lat1Hi   = 11'h0FF;
  localparam logic [CodeW-1:0] DjeLo    = 11'h402;
  localparam logic [CodeW-1:0] DjeHi    = 11'h403;
  localparam logic [CodeW-1:0] DjeOff   = 11'h382;
  localparam logic [ByteW-1:0] NulByte  = 8'h00;

  // Result of mapping one code point.
  typedef struct packed {
    logic             hit;
    logic [ByteW-1:0] cp_byte;
  } map_res_t;

  localparam logic [15:0] CodeTab [TabLen] = '{
    16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021, 16'h20AC, 16'h2030,
    16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F, 16'h0452, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h2122, 16'h0459,
    16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F, 16'h00A0, 16'h040E, 16'h045E,
    16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7, 16'h0401, 16'h00A9, 16'h0404,
    16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407, 16'h00B0, 16'h00B1, 16'h0406,
    16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7, 16'h0451, 16'h2116, 16'h0454,
    16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
  };

  localparam logic [ByteW-1:0] ByteTab [TabLen] = '{
    8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
    8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
    8'h96, 8'h97, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hA0,
    8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA,
    8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4,
    8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE,
    8'hBF
  };

endpackage

### rtl/u2c_map.sv
// Combinational mapper from an 11-bit code point to one Windows-1251 byte.
// Depends on u2c_pkg for the ranges and the match table.
module u2c_map (
  input  logic [u2c_pkg::CodeW-1:0] code_i,
  output u2c_pkg::map_res_t         res_o
);
  import u2c_pkg::*;

  logic [15:0] code_wide;
  logic [CodeW-1:0] cyr_diff;
  logic [CodeW-1:0] dje_diff;

  assign code_wide = {{(16-CodeW){1'b0}}, code_i};
  assign cyr_diff  = code_i - CyrOff;
  assign dje_diff  = code_i - DjeOff;

  always_comb begin
    res_o = '0;
    if (code_i >= CyrLo && code_i <= CyrHi) begin
      res_o.hit     = 1'b1;
      res_o.cp_byte = cyr_diff[ByteW-1:0];
    end else if (code_i >= Lat1Lo && code_i <= Lat1Hi) begin
      res_o.hit     = 1'b1;
      res_o.cp_byte = code_i[ByteW-1:0];
    end else if (code_i >= DjeLo && code_i <= DjeHi) begin
      res_o.hit     = 1'b1;
      res_o.cp_byte = dje_diff[ByteW-1:0];
    end else begin
      // Entries are distinct, so at most one comparator fires.
      for (int k = 0; k < TabLen; k++) begin
        if (code_wide == CodeTab[k]) begin
          res_o.hit     = 1'b1;
          res_o.cp_byte = ByteTab[k];
        end
      end
    end
  end

endmodule

### rtl/utf8_to_cp1251_transcoder.sv
// Top level of the UTF-8 to Windows-1251 transcoder: input register, decoder, result register.
// Depends on u2c_pkg and u2c_map.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------
//   in      | request   | in_valid_i/in_stall_o | in_byte_i
//   out     | result    | out_valid_o/out_stall_i | out_byte_o, conv_error_o, last_o
//
// A byte accepted into the input register is decoded into the result register when that
// is free or being emptied, and one byte enters per cycle while the output is not stalled;
// the rate is set by the single decode stage between the registers.
// Reset clears the decoder state (no lead pending, not discarding) and both valid flags.
// A stalled result holds the output register; the input register takes a byte while it is
// empty or being decoded, and in_stall_o is high while it holds a byte that cannot advance.
module utf8_to_cp1251_transcoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [u2c_pkg::ByteW-1:0] in_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [u2c_pkg::ByteW-1:0] out_byte_o,
  output logic                      conv_error_o,
  output logic                      last_o
);
  import u2c_pkg::*;

  // Input register.
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // Decoder state, advanced once per byte.
  logic             lead_pending_q, lead_pending_d;
  logic [LeadW-1:0] lead_bits_q, lead_bits_d;
  logic             discarding_q, discarding_d;

  // Result register.
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             conv_error_q;
  logic             last_q;

  logic             emit;
  logic [ByteW-1:0] emit_byte;
  logic             emit_err;
  logic             emit_last;
  logic             advance;
  logic             in_take;
  logic [CodeW-1:0] code;
  map_res_t         map_res;

  // The byte in the input register is decoded when the result register is free or
  // is being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Code point from the held lead bits and the low six bits of the second byte.
  assign code = {lead_bits_q, in_byte_q[5:0]};

  u2c_map u_map (
    .code_i (code),
    .res_o  (map_res)
  );

  always_comb begin
    emit           = 1'b0;
    emit_byte      = NulByte;
    emit_err       = 1'b0;
    emit_last      = 1'b0;
    lead_pending_d = lead_pending_q;
    lead_bits_d    = lead_bits_q;
    discarding_d   = discarding_q;
    if (discarding_q) begin
      // Bytes are dropped until the terminator of the broken string.
      if (in_byte_q == NulByte) begin
        discarding_d = 1'b0;
      end
    end else if (lead_pending_q) begin
      lead_pending_d = 1'b0;
      emit           = 1'b1;
      if (in_byte_q == NulByte) begin
        // A terminator cut the pair short; it ends the string itself.
        emit_err  = 1'b1;
        emit_last = 1'b1;
      end else if (map_res.hit) begin
        emit_byte = map_res.cp_byte;
      end else begin
        emit_err     = 1'b1;
        emit_last    = 1'b1;
        discarding_d = 1'b1;
      end
    end else if (in_byte_q == NulByte) begin
      emit      = 1'b1;
      emit_last = 1'b1;
    end else if (!in_byte_q[7]) begin
      emit      = 1'b1;
      emit_byte = in_byte_q;
    end else if (!in_byte_q[5]) begin
      lead_pending_d = 1'b1;
      lead_bits_d    = in_byte_q[LeadW-1:0];
    end else begin
      // Leads of three or more bytes, and stray bytes 0xA0 to 0xBF, cannot map to this code page.
      emit         = 1'b1;
      emit_err     = 1'b1;
      emit_last    = 1'b1;
      discarding_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      lead_pending_q <= 1'b0;
      lead_bits_q    <= '0;
      discarding_q   <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q    <= emit;
        lead_pending_q <= lead_pending_d;
        lead_bits_q    <= lead_bits_d;
        discarding_q   <= discarding_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
    end
    if (advance && emit) begin
      out_byte_q   <= emit_byte;
      conv_error_q <= emit_err;
      last_q       <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign conv_error_o = conv_error_q;
  assign last_o       = last_q;

endmodule

### rtl/u2c_checker.sv
// Port-level assertions for the transcoder and the bind that attaches them.
// Depends on u2c_pkg and on the top level utf8_to_cp1251_transcoder.
module u2c_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [u2c_pkg::ByteW-1:0] out_byte_o,
  input logic                      conv_error_o,
  input logic                      last_o
);
  import u2c_pkg::*;

  // A stalled result must hold its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(conv_error_o) && $stable(last_o))
    else $error("stalled result changed");

  // Every error ends the string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && conv_error_o |-> last_o)
    else $error("error result without last");

  // Only an ending result carries a zero byte, and every ending result does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_byte_o == NulByte) == last_o))
    else $error("zero byte and last disagree");

  // With an empty output side the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

endmodule

bind utf8_to_cp1251_transcoder u2c_checker u_u2c_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .conv_error_o (conv_error_o),
  .last_o       (last_o)
);

### test/testbench.sv
// Self-checking testbench for the UTF-8 to Windows-1251 transcoder.
// Depends on u2c_pkg and the RTL of utf8_to_cp1251_transcoder; holds its own
// byte-level predictor and code table, and needs no files at run time.
module testbench;

  import u2c_pkg::ByteW;

  // Limit on the idle run, with no request and no result, at which the watchdog ends the run.
  localparam int unsigned IdleLimit = 2000;
  // Least number of random bytes to send, and how many of the last ones go out with no idling.
  localparam int unsigned RandomBytes = 450;
  localparam int unsigned QuietTail   = 60;

  // Code points that the fixed ranges do not cover, and their Windows-1251 bytes.
  // Entries above 0x7FF cannot be formed from two UTF-8 bytes, but they are kept
  // so that the table matches the character set as a whole.
  localparam logic [15:0] WinCodes [61] = '{
    16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021, 16'h20AC, 16'h2030,
    16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F, 16'h0452, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h2122, 16'h0459,
    16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F, 16'h00A0, 16'h040E, 16'h045E,
    16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7, 16'h0401, 16'h00A9, 16'h0404,
    16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407, 16'h00B0, 16'h00B1, 16'h0406,
    16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7, 16'h0451, 16'h2116, 16'h0454,
    16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
  };

  localparam logic [7:0] WinBytes [61] = '{
    8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
    8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
    8'h96, 8'h97, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hA0,
    8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA,
    8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4,
    8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE,
    8'hBF
  };

  // One output byte of the transcoder as the predictor sees it.
  typedef struct packed {
    logic [7:0] win_byte;
    logic       bad_char;
    logic       ends_string;
  } win_char_t;

  // Maps an 11-bit code point to its Windows-1251 byte. Cyrillic capitals and
  // small letters form one block, Latin-1 passes as is, and the two Serbian
  // letters right above the Cyrillic start have their own offset; everything
  // else must be found in the table. Returns 0 when the code point has no byte.
  function automatic bit map_to_cp1251(input logic [10:0] cp, output logic [7:0] win);
    win = 8'h00;
    if (cp >= 11'h410 && cp <= 11'h44F) begin
      win = 8'(cp - 11'h350);
      return 1'b1;
    end
    if (cp >= 11'h080 && cp <= 11'h0FF) begin
      win = cp[7:0];
      return 1'b1;
    end
    if (cp >= 11'h402 && cp <= 11'h403) begin
      win = 8'(cp - 11'h382);
      return 1'b1;
    end
    for (int k = 0; k < 61; k++) begin
      if (WinCodes[k] == {5'b00000, cp}) begin
        win = WinBytes[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Tracks the decoder state byte by byte and keeps the bytes still to come out.
  class cp1251_scoreboard;
    win_char_t  expected_q[$];
    bit         lead_held;
    logic [4:0] lead_hi = '0;
    bit         dropping;
    int         mismatch_cnt;
    int         checked_cnt;
    int         bad_char_cnt;

    function void note_input(logic [7:0] b);
      logic [10:0] cp;
      logic [7:0]  win;
      // After an error the rest of the string is thrown away; its zero byte
      // only rearms the decoder, since the error already ended the string.
      if (dropping) begin
        if (b == 8'h00) dropping = 1'b0;
        return;
      end
      if (lead_held) begin
        lead_held = 1'b0;
        // A string that ends in the middle of a character is an error, but
        // the zero still closes it, so nothing is dropped afterwards.
        if (b == 8'h00) begin
          expected_q.push_back('{8'h00, 1'b1, 1'b1});
          return;
        end
        // The trail byte is not checked for the 10xxxxxx pattern.
        cp = {lead_hi, b[5:0]};
        if (map_to_cp1251(cp, win)) begin
          expected_q.push_back('{win, 1'b0, 1'b0});
        end else begin
          dropping = 1'b1;
          expected_q.push_back('{8'h00, 1'b1, 1'b1});
        end
        return;
      end
      if (b == 8'h00) begin
        expected_q.push_back('{8'h00, 1'b0, 1'b1});
      end else if (!b[7]) begin
        expected_q.push_back('{b, 1'b0, 1'b0});
      end else if (!b[5]) begin
        // Two-byte lead: nothing comes out until the trail byte arrives.
        lead_held = 1'b1;
        lead_hi   = b[4:0];
      end else begin
        // Leads of three or more bytes, and stray bytes 0xA0 to 0xBF, are not supported.
        dropping = 1'b1;
        expected_q.push_back('{8'h00, 1'b1, 1'b1});
      end
    endfunction

    function void check_result(logic [7:0] win, logic bad, logic ends);
      win_char_t want;
      checked_cnt++;
      if (bad) bad_char_cnt++;
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: byte %02h error %0b last %0b", win, bad, ends);
        return;
      end
      want = expected_q.pop_front();
      if (want.win_byte !== win || want.bad_char !== bad || want.ends_string !== ends) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display({"mismatch at result %0d: expected byte %02h error %0b last %0b,",
                    " got byte %02h error %0b last %0b"},
                   checked_cnt, want.win_byte, want.bad_char, want.ends_string,
                   win, bad, ends);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // Clock, reset and all block inputs start at known values.
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [ByteW-1:0] in_byte_i   = '0;
  logic             out_stall_i = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [ByteW-1:0] out_byte_o;
  logic             conv_error_o;
  logic             last_o;

  cp1251_scoreboard sb = new();
  logic [7:0]       stim_q [$];
  bit               quiet;
  int               sent_cnt;
  int               string_cnt;
  int               idle_run;

  always #10 clk_i = ~clk_i;

  utf8_to_cp1251_transcoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .conv_error_o (conv_error_o),
    .last_o       (last_o)
  );

  // Offers one request byte and returns at the edge where it is taken. Before the
  // byte, the sender sometimes goes idle for a burst of cycles. Valid stays high
  // from one byte to the next when there is no gap, so it is never dropped and
  // raised again within one time step.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b);
    sent_cnt++;
    if (b == 8'h00) string_cnt++;
  endtask

  // Holds the sender off until every predicted byte has come out. It always waits for a
  // clock edge before it returns, so valid is never lowered and raised in the same step.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Two-byte UTF-8 form of an 11-bit code point.
  function automatic void push_code(input logic [10:0] cp);
    stim_q.push_back({3'b110, cp[10:6]});
    stim_q.push_back({2'b10, cp[5:0]});
  endfunction

  // Builds the random stream as strings of characters closed by a zero. Most
  // characters are well formed, so the decoder spends its time in the lead and
  // trail states; the rest are random bytes, long leads, code points with no
  // Windows-1251 byte, and strings cut off right after a lead.
  function automatic void build_random_stream();
    logic [10:0] cp;
    logic [7:0]  junk;
    int          k;
    while (stim_q.size() < RandomBytes) begin
      repeat ($urandom_range(1, 12)) begin
        k = $urandom_range(0, 99);
        if (k < 45) begin
          stim_q.push_back(8'($urandom_range(1, 127)));
        end else if (k < 85) begin
          case ($urandom_range(0, 3))
            0: cp = 11'h410 + 11'($urandom_range(0, 63));
            1: cp = 11'h080 + 11'($urandom_range(0, 127));
            2: cp = 11'h402 + 11'($urandom_range(0, 1));
            default: begin
              do k = $urandom_range(0, 60); while (WinCodes[k] > 16'h07FF);
              cp = WinCodes[k][10:0];
            end
          endcase
          push_code(cp);
        end else begin
          case ($urandom_range(0, 3))
            0: stim_q.push_back(8'($urandom_range(1, 255)));
            1: stim_q.push_back(8'($urandom_range(8'hE0, 8'hFF)));
            2: begin
              do cp = 11'($urandom_range(0, 2047)); while (map_to_cp1251(cp, junk));
              push_code(cp);
            end
            default: begin
              stim_q.push_back({3'b110, 5'($urandom_range(0, 31))});
              stim_q.push_back(8'h00);
            end
          endcase
        end
      end
      stim_q.push_back(8'h00);
    end
  endfunction

  // Result side: stalls come in bursts of random length between free stretches
  // of varying length, some of them long. In the quiet tail there are none; every
  // burst ends with the stall low, so the quiet tail only has to wait.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (quiet) begin
        @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(30, 80)) @(posedge clk_i);
        else repeat ($urandom_range(1, 12)) @(posedge clk_i);
        if (!quiet) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and watchdog. Both sample the values held just before the
  // edge, so they do not depend on the order of processes within the step.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_byte_o, conv_error_o, last_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= IdleLimit) begin
        $display("watchdog: no request or result for %0d cycles", IdleLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Request side: reset, a directed string set, a full drain, then the random
  // stream with a second drain halfway through and a quiet tail at the end.
  initial begin
    logic [7:0] directed_q [$];
    directed_q = {
      8'h00,                 // empty string
      8'h7F,                 // highest plain ASCII byte
      8'hD0, 8'h90,          // first Cyrillic capital
      8'hD1, 8'h8F,          // last Cyrillic small letter
      8'hC2, 8'h80,          // lowest Latin-1 code point
      8'hC3, 8'hBF,          // highest Latin-1 code point
      8'hD0, 8'h82,          // Serbian range
      8'hD0, 8'h89,          // table hit
      8'hD2, 8'h91,          // table hit at code point 0x491
      8'hD0, 8'h10,          // trail byte without the continuation pattern
      8'h00,
      8'hC0, 8'h80, 8'h41,   // overlong form: error, then the 'A' is dropped
      8'h00,                 // ends the dropping quietly
      8'hFF, 8'h80, 8'h00,   // long lead: error, then dropping until zero
      8'hD0, 8'h00           // string cut off after a lead
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_byte(directed_q[i]);
    wait_drained();

    build_random_stream();
    foreach (stim_q[i]) begin
      if (i == stim_q.size() / 2) wait_drained();
      if (i + QuietTail >= stim_q.size()) quiet = 1'b1;
      send_byte(stim_q[i]);
    end

    // Everything is sent: wait for the last results, then keep the clock running to
    // catch anything the block might still put out on its own.
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; %0d bytes came back, %0d of them flagged errors.",
             sent_cnt, string_cnt, sb.checked_cnt, sb.bad_char_cnt);
    $display("Mismatches: %0d, results still awaited: %0d.", sb.mismatch_cnt, sb.pending());
    if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/u2c_pkg.sv
rtl/u2c_map.sv
rtl/utf8_to_cp1251_transcoder.sv
rtl/u2c_checker.sv
test/testbench.sv
